[design/bfbp_pkg.sv]
// Package for the Bloom filter build/probe block: sizing limits, widths,
// register indexes, reset values, command codes, the structs passed between the
// submodules and a saturating counter increment. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfbp_pkg;

  // Sizing limits
  localparam int unsigned MaxFilterBits = 1048576;
  localparam int unsigned HashCountMax  = 16;
  localparam int unsigned MinSizeBits   = 64;

  // Field widths
  localparam int unsigned HashW    = 64;
  localparam int unsigned SizeW    = 21;
  localparam int unsigned HashCntW = 5;
  localparam int unsigned CountW   = 32;
  localparam int unsigned WordW    = 64;
  localparam int unsigned BitSelW  = 6;
  localparam int unsigned PosW     = 6;
  localparam int unsigned NhW      = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = SizeW;

  typedef logic [CountW-1:0] count_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeBits  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNumHashes = 2'd2;

  // Configuration reset values
  localparam logic                EnableRst    = 1'b1;
  localparam logic [SizeW-1:0]    SizeBitsRst  = 21'd65536;
  localparam logic [HashCntW-1:0] NumHashesRst = 5'd4;

  // Item commands
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdProbe  = 1'b1;

  // Control from the sequencer to the index generator
  typedef struct packed {
    logic load;
    logic step;
  } idx_ctrl_t;

  // Status of the bit position consumed by the current step
  typedef struct packed {
    logic want;  // position is below the hash count: an index comes out
    logic last;  // position zero: final index of the key
  } idx_status_t;

  // Saturating increment of a statistics counter
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : v + count_t'(1);
  endfunction

endpackage

[design/bfbp_if.sv]
// Valid/ready channel interfaces for the Bloom filter block: one for input
// items, one for result items. Depends on bfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfbp_in_if;
  import bfbp_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [HashW-1:0] hash;
  logic             key_valid;

  modport source (output valid, command, hash, key_valid, input ready);
  modport sink   (input valid, command, hash, key_valid, output ready);
endinterface

interface bfbp_out_if;
  import bfbp_pkg::*;

  logic   valid;
  logic   ready;
  logic   keep;
  logic   order_error;
  count_t inserted_total;
  count_t probed_total;
  count_t filtered_total;

  modport source (output valid, keep, order_error, inserted_total, probed_total,
                  filtered_total, input ready);
  modport sink   (input valid, keep, order_error, inserted_total, probed_total,
                  filtered_total, output ready);
endinterface

`default_nettype wire

[design/bfbp_store.sv]
// Filter bit store: one-port-read, one-port-write synchronous memory of
// 64-bit words, with a clearing sweep after reset. Depends on bfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbp_store #(
  parameter  int unsigned Words = bfbp_pkg::MaxFilterBits / bfbp_pkg::WordW,
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [AddrW-1:0]          rd_addr_i,
  output logic      [bfbp_pkg::WordW-1:0] rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [AddrW-1:0]          wr_addr_i,
  input  wire logic [bfbp_pkg::WordW-1:0] wr_data_i,
  output logic                           ready_o
);
  import bfbp_pkg::*;

  logic [WordW-1:0] mem_q [Words];
  logic [WordW-1:0] rd_data_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             clearing_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordW-1:0] wdata;

  // Sweep every word to zero, one per cycle, after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Words - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Let the sweep own the write port while it runs
  always_comb begin
    we    = clearing_q | wr_en_i;
    waddr = clearing_q ? clr_addr_q : wr_addr_i;
    wdata = clearing_q ? '0 : wr_data_i;
  end

  // Memory array with registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clearing_q;

endmodule

`default_nettype wire

[design/bfbp_idx.sv]
// Bit index generator: serial remainder of the hash by the filter size, one
// hash bit per step from the top; after the step on bit i the remainder is
// (hash >> i) mod size. Depends on bfbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbp_idx #(
  parameter  int unsigned MaxBits = bfbp_pkg::MaxFilterBits,
  localparam int unsigned RemW    = $clog2(MaxBits)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bfbp_pkg::idx_ctrl_t            ctrl_i,
  input  wire logic [bfbp_pkg::HashW-1:0]     hash_i,
  input  wire logic [bfbp_pkg::SizeW-1:0]     size_bits_i,
  input  wire logic [bfbp_pkg::HashCntW-1:0]  num_hashes_i,
  output logic      [RemW-1:0]                rem_next_o,
  output bfbp_pkg::idx_status_t               status_o
);
  import bfbp_pkg::*;

  localparam int unsigned SzW = $clog2(MaxBits + 1);
  localparam int unsigned DW  = SzW + 1;
  localparam int unsigned CW  = (SzW > SizeW) ? SzW : SizeW;

  logic [HashW-1:0] hash_q;
  logic [PosW-1:0]  pos_q;
  logic [RemW-1:0]  rem_q;
  logic [SzW-1:0]   size_q;
  logic [NhW-1:0]   nh_q;
  logic [CW-1:0]    size_raw;
  logic [SzW-1:0]   size_eff;
  logic [NhW-1:0]   nh_raw;
  logic [NhW-1:0]   nh_eff;
  logic [DW-1:0]    trial;
  logic [DW-1:0]    size_ext;

  // Clamp size and hash count into their usable ranges
  always_comb begin
    size_raw = CW'(size_bits_i);
    if (size_raw < CW'(MinSizeBits)) begin
      size_eff = SzW'(MinSizeBits);
    end else if (size_raw > CW'(MaxBits)) begin
      size_eff = SzW'(MaxBits);
    end else begin
      size_eff = SzW'(size_raw);
    end
    nh_raw = NhW'(num_hashes_i);
    if (nh_raw == '0) begin
      nh_eff = NhW'(1);
    end else if (nh_raw > NhW'(HashCountMax)) begin
      nh_eff = NhW'(HashCountMax);
    end else begin
      nh_eff = nh_raw;
    end
  end

  // Shift in the next hash bit, subtract the size once if needed
  always_comb begin
    trial      = DW'({rem_q, hash_q[pos_q]});
    size_ext   = DW'(size_q);
    rem_next_o = (trial >= size_ext) ? RemW'(trial - size_ext) : RemW'(trial);
    status_o.want = ({1'b0, pos_q} < nh_q);
    status_o.last = (pos_q == '0);
  end

  // Load a new key or advance one bit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '1;
      rem_q  <= '0;
      size_q <= SzW'(MinSizeBits);
      nh_q   <= NhW'(1);
    end else if (ctrl_i.load) begin
      pos_q  <= '1;
      rem_q  <= '0;
      size_q <= size_eff;
      nh_q   <= nh_eff;
    end else if (ctrl_i.step) begin
      pos_q  <= pos_q - PosW'(1);
      rem_q  <= rem_next_o;
    end
  end

  // Hold the key hash
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      hash_q <= hash_i;
    end
  end

endmodule

`default_nettype wire

[design/bloom_filter_build_probe_top.sv]
// Bloom filter build/probe block: sequencer, configuration registers and
// statistics counters around the bit store and the index generator.
// An item that touches no bits goes from accept straight to its result; otherwise
// it runs 64 serial remainder steps, one per hash bit, plus one read-modify-write
// per index; a probe that misses ends at that index.
// One item at a time: a new item is accepted only once the last result is posted,
// which waits while an earlier result is stalled. After reset the store's
// MaxFilterBits/64 words (16384 by default) are swept to zero with in_i.ready low.
`timescale 1ns / 1ps
`default_nettype none

module bloom_filter_build_probe_top #(
  parameter int unsigned MaxFilterBits = bfbp_pkg::MaxFilterBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bfbp_in_if.sink                            in_i,
  bfbp_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bfbp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bfbp_pkg::*;

  localparam int unsigned Words = (MaxFilterBits + WordW - 1) / WordW;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned RemW  = $clog2(MaxFilterBits);

  typedef enum logic [1:0] {StIdle, StDivide, StCheck, StFinish} state_e;

  state_e               state_q, state_d;
  logic                 enable_q;
  logic [SizeW-1:0]     size_bits_q;
  logic [HashCntW-1:0]  num_hashes_q;
  logic                 cmd_q, cmd_d;
  logic                 hit_q, hit_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [BitSelW-1:0]   bitsel_q, bitsel_d;
  logic                 last_q, last_d;
  logic                 probing_q, probing_d;
  count_t               inserted_q, inserted_d;
  count_t               probed_q, probed_d;
  count_t               filtered_q, filtered_d;
  logic                 out_valid_q, out_valid_d;
  logic                 keep_q, keep_d;
  logic                 oerr_q, oerr_d;

  idx_ctrl_t            idx_ctrl;
  idx_status_t          idx_status;
  logic [RemW-1:0]      rem_next;
  logic                 store_ready;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [WordW-1:0]     rd_data;
  logic                 wr_en;
  logic [WordW-1:0]     wr_data;
  logic                 in_acc;
  logic                 bit_set;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= EnableRst;
      size_bits_q  <= SizeBitsRst;
      num_hashes_q <= NumHashesRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEnable:    enable_q     <= cfg_wdata_i[0];
        CfgSizeBits:  size_bits_q  <= cfg_wdata_i[SizeW-1:0];
        CfgNumHashes: num_hashes_q <= cfg_wdata_i[HashCntW-1:0];
        default:      ;
      endcase
    end
  end

  bfbp_idx #(
    .MaxBits (MaxFilterBits)
  ) u_idx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (idx_ctrl),
    .hash_i       (in_i.hash),
    .size_bits_i  (size_bits_q),
    .num_hashes_i (num_hashes_q),
    .rem_next_o   (rem_next),
    .status_o     (idx_status)
  );

  bfbp_store #(
    .Words (Words)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_data),
    .ready_o   (store_ready)
  );

  assign in_i.ready = (state_q == StIdle) && store_ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign rd_addr    = AddrW'(rem_next >> BitSelW);
  assign bit_set    = rd_data[bitsel_q];
  assign wr_data    = rd_data | (WordW'(1) << bitsel_q);

  // Sequence one item: divide, read-modify-write per index, then post result
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    hit_d       = hit_q;
    addr_d      = addr_q;
    bitsel_d    = bitsel_q;
    last_d      = last_q;
    probing_d   = probing_q;
    inserted_d  = inserted_q;
    probed_d    = probed_q;
    filtered_d  = filtered_q;
    keep_d      = keep_q;
    oerr_d      = oerr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    idx_ctrl    = '0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_d         = in_i.command;
          hit_d         = in_i.key_valid;
          idx_ctrl.load = 1'b1;
          state_d       = (enable_q && in_i.key_valid) ? StDivide : StFinish;
        end
      end
      StDivide: begin
        idx_ctrl.step = 1'b1;
        if (idx_status.want) begin
          rd_en    = 1'b1;
          addr_d   = rd_addr;
          bitsel_d = rem_next[BitSelW-1:0];
          last_d   = idx_status.last;
          state_d  = StCheck;
        end
      end
      StCheck: begin
        if (cmd_q == CmdInsert) begin
          wr_en = 1'b1;
        end
        if ((cmd_q == CmdProbe) && !bit_set) begin
          hit_d   = 1'b0;
          state_d = StFinish;
        end else if (last_q) begin
          state_d = StFinish;
        end else begin
          state_d = StDivide;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          keep_d      = 1'b0;
          oerr_d      = 1'b0;
          if (cmd_q == CmdInsert) begin
            oerr_d     = probing_q;
            inserted_d = sat_inc(inserted_q);
          end else if (!enable_q) begin
            keep_d = 1'b1;
          end else begin
            probing_d = 1'b1;
            probed_d  = sat_inc(probed_q);
            keep_d    = hit_q;
            if (!hit_q) begin
              filtered_d = sat_inc(filtered_q);
            end
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state, counters and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      probing_q   <= 1'b0;
      inserted_q  <= '0;
      probed_q    <= '0;
      filtered_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      probing_q   <= probing_d;
      inserted_q  <= inserted_d;
      probed_q    <= probed_d;
      filtered_q  <= filtered_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    hit_q    <= hit_d;
    addr_q   <= addr_d;
    bitsel_q <= bitsel_d;
    last_q   <= last_d;
    keep_q   <= keep_d;
    oerr_q   <= oerr_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.keep           = keep_q;
  assign out_o.order_error    = oerr_q;
  assign out_o.inserted_total = inserted_q;
  assign out_o.probed_total   = probed_q;
  assign out_o.filtered_total = filtered_q;

endmodule

`default_nettype wire

[design/bfbp_checker.sv]
// Port-level checks for the Bloom filter block, bound to the top level.
// Depends on bfbp_pkg and bloom_filter_build_probe_top.
`timescale 1ns / 1ps
`default_nettype none

module bfbp_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic             keep_i,
  input wire logic             order_error_i,
  input wire bfbp_pkg::count_t inserted_total_i,
  input wire bfbp_pkg::count_t probed_total_i,
  input wire bfbp_pkg::count_t filtered_total_i
);
  import bfbp_pkg::*;

  // Store sweep keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("input ready right after reset");

  // One item at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready in the cycle after an accepted item");

  // Rejected probes never outnumber probes
  a_filtered_le_probed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (filtered_total_i <= probed_total_i))
    else $error("filtered total above probed total");

  // Order error implies probing has happened and the item is no kept probe
  a_order_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && order_error_i) |-> (probed_total_i != '0) && !keep_i)
    else $error("order error without probes or on a kept item");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(keep_i)
      && $stable(order_error_i) && $stable(inserted_total_i)
      && $stable(probed_total_i) && $stable(filtered_total_i))
    else $error("stalled result changed");

endmodule

bind bloom_filter_build_probe_top bfbp_checker u_bfbp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .keep_i           (out_o.keep),
  .order_error_i    (out_o.order_error),
  .inserted_total_i (out_o.inserted_total),
  .probed_total_i   (out_o.probed_total),
  .filtered_total_i (out_o.filtered_total)
);

`default_nettype wire
